[rtl/nss_pkg.sv]
// Shared types and constants for the nonlinear slew smoother.
`default_nettype none
package nss_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int TS_W            = 24;   // time_step and rate_multiplier width
  localparam int SAT_W           = 64;   // saturation range of the products
  localparam int MACC_W          = 80;   // raw product width, above SAT_W
  localparam int CFG_IDX_W       = 3;
  localparam int OP_W            = 2;

  localparam logic [SAT_W-1:0] SATV = '1;

  localparam logic [OP_W-1:0] OP_BASE     = 2'd0;
  localparam logic [OP_W-1:0] OP_OVERRIDE = 2'd1;
  localparam logic [OP_W-1:0] OP_SCALED   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEARITY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_LSQ,
    ST_NUM,
    ST_DIV,
    ST_W1,
    ST_W2,
    ST_P,
    ST_M,
    ST_OUT
  } step_t;

  typedef struct packed {
    step_t step;
    logic  in_ready;
    logic  mul_start;
    logic  div_start;
    logic  finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic scaled;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

[rtl/nonlinear_slew_smoother.sv]
// Top level of the nonlinear slew smoother: controller plus datapath.
//
// Moves a tracked level toward target_value by at most
// time_step * rate_eff * (d*(1-L^2) + L^2*span) per beat, never past it.
// Channels: input beats (operation, target_value, time_step, rate_override,
// rate_multiplier) on in_valid/in_ready; one result beat (smoothed_value)
// per input beat on out_valid/out_ready; configuration writes on
// cfg_valid/cfg_ready with cfg_index/cfg_data, always ready, to be issued
// only while the block is idle. Writing start_value reloads the level.
// One item is worked at a time, with seven products (six when the beat is
// not scaled) on a shared shift-add multiplier that retires one
// multiplier bit per cycle and stops early on the top set bit, plus an
// 80-step restoring divider for the rate gain. in_ready rises once the
// previous result sits in the output register, so the next beat can be
// taken while that result still waits. A stalled receiver holds the
// finished item in its last step; nothing is dropped. Reset (rst,
// synchronous) restores register defaults and clears the level to zero.
`default_nettype none
module nonlinear_slew_smoother import nss_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [VALUE_WIDTH-1:0]        cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [OP_W-1:0]               operation,
  input  wire logic signed [VALUE_WIDTH-1:0] target_value,
  input  wire logic [TS_W-1:0]               time_step,
  input  wire logic [VALUE_WIDTH-1:0]        rate_override,
  input  wire logic [TS_W-1:0]               rate_multiplier,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0]      smoothed_value
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;
  assign in_ready  = cmd.in_ready;

  nss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  nss_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .operation       (operation),
    .target_value    (target_value),
    .time_step       (time_step),
    .rate_override   (rate_override),
    .rate_multiplier (rate_multiplier),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .smoothed_value  (smoothed_value),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
`default_nettype wire

[rtl/nss_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle, saturating at 64 bits.
`default_nettype none
module nss_mul import nss_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SAT_W-1:0]  a,
  input  wire logic [SAT_W-1:0]  b,
  output logic                   done,
  output logic [SAT_W-1:0]       res,
  output logic [MACC_W-1:0]      raw
);

  logic              busy;
  logic [MACC_W-1:0] acc;
  logic [MACC_W-1:0] ash;
  logic              aovf;
  logic [SAT_W-1:0]  bsh;
  logic              ovf;
  logic              zero;
  logic              sticky;
  logic [MACC_W:0]   sum;

  assign sum = {1'b0, acc} + {1'b0, ash};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        acc    <= '0;
        ash    <= MACC_W'(a);
        aovf   <= 1'b0;
        bsh    <= b;
        ovf    <= 1'b0;
        zero   <= (a == '0) || (b == '0);
        sticky <= (a == SATV) || (b == SATV);
      end else if (busy) begin
        if (bsh == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (bsh[0]) begin
            acc <= sum[MACC_W-1:0];
            ovf <= ovf | sum[MACC_W] | aovf;
          end
          aovf <= aovf | ash[MACC_W-1];
          ash  <= ash << 1;
          bsh  <= bsh >> 1;
        end
      end
    end
  end

  assign raw = acc;

  always_comb begin
    if (zero) begin
      res = '0;
    end else if (sticky || ovf || (acc[MACC_W-1:SAT_W] != '0)) begin
      res = SATV;
    end else begin
      res = acc[SAT_W-1:0] >> FRAC_BITS;
    end
  end

endmodule
`default_nettype wire

[rtl/nss_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module nss_div import nss_pkg::*; #(
  parameter int DEN_W = DEF_FRAC_BITS + 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [MACC_W-1:0] dividend,
  input  wire logic [DEN_W-1:0]  divisor,
  output logic                   done,
  output logic [MACC_W-1:0]      quo
);

  localparam int CNT_W = $clog2(MACC_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[MACC_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MACC_W);
        rem  <= '0;
        den  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
          quo <= {quo[MACC_W-2:0], fits};
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/nss_dp.sv]
// Datapath: registers, operand selection, shared multiplier and divider.
`default_nettype none
module nss_dp import nss_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [VALUE_WIDTH-1:0]        cfg_data,
  input  wire logic                          in_valid,
  input  wire logic [OP_W-1:0]               operation,
  input  wire logic signed [VALUE_WIDTH-1:0] target_value,
  input  wire logic [TS_W-1:0]               time_step,
  input  wire logic [VALUE_WIDTH-1:0]        rate_override,
  input  wire logic [TS_W-1:0]               rate_multiplier,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic signed [VALUE_WIDTH-1:0]      smoothed_value,
  input  wire ctrl_cmd_t                     cmd,
  output ctrl_sts_t                          sts
);

  localparam int VW    = VALUE_WIDTH;
  localparam int LW    = FRAC_BITS + 1;
  localparam int DEN_W = FRAC_BITS + 4;
  localparam logic [LW-1:0]    ONE_L = LW'(1) << FRAC_BITS;
  localparam logic [SAT_W-1:0] VMAX  = SAT_W'({VW{1'b1}});

  logic [VW-1:0]     base_rate;
  logic [LW-1:0]     lin;
  logic [VW-1:0]     low_lim;
  logic [VW-1:0]     high_lim;
  logic [VW-1:0]     level;

  logic [OP_W-1:0]   op;
  logic [VW-1:0]     target;
  logic [TS_W-1:0]   dt;
  logic [TS_W-1:0]   mult;
  logic [VW-1:0]     rate;
  logic [LW-1:0]     lsq;
  logic [SAT_W-1:0]  rate_eff;
  logic [SAT_W-1:0]  w;
  logic [SAT_W-1:0]  p;
  logic [SAT_W-1:0]  m;
  logic [VW:0]       dist_mag;
  logic [VW:0]       span;

  logic [LW-1:0]     linc;
  logic [DEN_W-1:0]  lsq3;
  logic [DEN_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [VW:0]       tdiff;
  logic [VW:0]       sdiff;
  logic [SAT_W-1:0]  ma;
  logic [SAT_W-1:0]  mb;
  logic              mul_done;
  logic [SAT_W-1:0]  mres;
  logic [MACC_W-1:0] mraw;
  logic              div_done;
  logic [MACC_W-1:0] quo;
  logic              accept;

  assign accept = in_valid && cmd.in_ready;

  assign linc = (lin > ONE_L) ? ONE_L : lin;
  assign lsq3 = (DEN_W'(lsq) << 1) + DEN_W'(lsq);
  assign num  = lsq3 + (DEN_W'(1) << (FRAC_BITS + 2));
  assign den  = (lsq3 + (DEN_W'(1) << FRAC_BITS)) << 1;

  assign tdiff = {target_value[VW-1], target_value} - {level[VW-1], level};
  assign sdiff = {high_lim[VW-1], high_lim} - {low_lim[VW-1], low_lim};

  always_comb begin
    unique case (cmd.step)
      ST_RATE: begin ma = SAT_W'(base_rate); mb = SAT_W'(mult);            end
      ST_LSQ:  begin ma = SAT_W'(linc);      mb = SAT_W'(linc);            end
      ST_NUM:  begin ma = SAT_W'(rate);      mb = SAT_W'(num);             end
      ST_W1:   begin ma = SAT_W'(dist_mag);  mb = SAT_W'(ONE_L - lsq);     end
      ST_W2:   begin ma = SAT_W'(lsq);       mb = SAT_W'(span);            end
      ST_P:    begin ma = w;                 mb = rate_eff;                end
      ST_M:    begin ma = p;                 mb = SAT_W'(dt);              end
      default: begin ma = '0;                mb = '0;                      end
    endcase
  end

  nss_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .res   (mres),
    .raw   (mraw)
  );

  nss_div #(.DEN_W(DEN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mraw),
    .divisor  (den),
    .done     (div_done),
    .quo      (quo)
  );

  // item and intermediate registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= operation;
      target   <= target_value;
      dt       <= time_step;
      mult     <= rate_multiplier;
      rate     <= (operation == OP_OVERRIDE) ? rate_override : base_rate;
      dist_mag <= tdiff[VW] ? (VW+1)'(-tdiff) : tdiff;
      if (sdiff == '0) begin
        span <= (VW+1)'(ONE_L);
      end else begin
        span <= sdiff[VW] ? (VW+1)'(-sdiff) : sdiff;
      end
    end
    if (div_done) begin
      rate_eff <= quo[SAT_W-1:0];
    end
    if (mul_done) begin
      unique case (cmd.step)
        ST_RATE: rate <= (mres > VMAX) ? VW'(VMAX) : mres[VW-1:0];
        ST_LSQ:  lsq  <= mres[LW-1:0];
        ST_W1:   w    <= mres;
        ST_W2:   w    <= ((w == SATV) || (mres > SATV - w)) ? SATV : w + mres;
        ST_P:    p    <= mres;
        ST_M:    m    <= mres;
        default: ;
      endcase
    end
  end

  // configuration, tracked level and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_rate <= VW'(ONE_L);
      lin       <= '0;
      low_lim   <= '0;
      high_lim  <= VW'(ONE_L);
      level     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BASE_RATE:  base_rate <= cfg_data;
          CFG_LINEARITY:  lin       <= LW'(cfg_data);
          CFG_LOW_LIMIT:  low_lim   <= cfg_data;
          CFG_HIGH_LIMIT: high_lim  <= cfg_data;
          CFG_START:      level     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (m >= SAT_W'(dist_mag)) begin
          level          <= target;
          smoothed_value <= target;
        end else if ($signed(target) > $signed(level)) begin
          level          <= level + m[VW-1:0];
          smoothed_value <= level + m[VW-1:0];
        end else begin
          level          <= level - m[VW-1:0];
          smoothed_value <= level - m[VW-1:0];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.scaled   = (op == OP_SCALED);
  assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

[rtl/nss_ctrl.sv]
// Controller: sequences the steps of one item through the datapath.
`default_nettype none
module nss_ctrl import nss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  step_t state;
  step_t state_next;
  logic  fresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fresh <= 1'b0;
    end else begin
      state <= state_next;
      fresh <= (state_next != state);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_RATE;
      ST_RATE: if (!sts.scaled || sts.mul_done) state_next = ST_LSQ;
      ST_LSQ:  if (sts.mul_done) state_next = ST_NUM;
      ST_NUM:  if (sts.mul_done) state_next = ST_DIV;
      ST_DIV:  if (sts.div_done) state_next = ST_W1;
      ST_W1:   if (sts.mul_done) state_next = ST_W2;
      ST_W2:   if (sts.mul_done) state_next = ST_P;
      ST_P:    if (sts.mul_done) state_next = ST_M;
      ST_M:    if (sts.mul_done) state_next = ST_OUT;
      ST_OUT:  if (sts.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.step      = state;
    cmd.in_ready  = (state == ST_IDLE);
    cmd.div_start = fresh && (state == ST_DIV);
    cmd.finish    = (state == ST_OUT) && sts.out_free;
    unique case (state)
      ST_RATE:                               cmd.mul_start = fresh && sts.scaled;
      ST_LSQ, ST_NUM, ST_W1, ST_W2, ST_P, ST_M: cmd.mul_start = fresh;
      default:                               cmd.mul_start = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[test/tb_nonlinear_slew_smoother.sv]
// Self-checking testbench for the nonlinear slew smoother: directed table plus random beats.
`default_nettype none
module tb_nonlinear_slew_smoother;
  import nss_pkg::*;

  localparam int VW = 32;
  localparam int FB = 16;
  localparam logic [63:0] ONE = 64'd1 << FB;
  localparam int N_RANDOM = 1800;
  localparam int STALL_LIMIT = 20000;   // allows for the slowest item plus long receiver stalls
  localparam int DRAIN_CYCLES = 400;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;   // undefined code, acts as base rate

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [OP_W-1:0] operation;
  logic signed [VW-1:0] target_value;
  logic [TS_W-1:0] time_step;
  logic [VW-1:0] rate_override;
  logic [TS_W-1:0] rate_multiplier;
  logic out_valid, out_ready;
  logic signed [VW-1:0] smoothed_value;

  nonlinear_slew_smoother u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .target_value(target_value), .time_step(time_step), .rate_override(rate_override),
    .rate_multiplier(rate_multiplier), .out_valid(out_valid), .out_ready(out_ready),
    .smoothed_value(smoothed_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  typedef struct {
    logic [OP_W-1:0] op;
    logic signed [VW-1:0] tgt;
    logic [TS_W-1:0] dt;
    logic [VW-1:0] ovr;
    logic [TS_W-1:0] mult;
    logic has_exp;            // expected level typed in by hand
    logic signed [VW-1:0] exp_level;
  } step_row_t;

  // predictor copy of the registers and the level
  logic [VW-1:0] m_base_rate;
  logic [16:0] m_linearity;
  logic signed [VW-1:0] m_low, m_high;
  logic signed [VW-1:0] m_level;

  logic signed [VW-1:0] level_q[$];
  int errors;
  int idle_cycles;
  bit quiet;                  // stretch with no idling on either side

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // (a*b)>>FB with sticky saturation at all-ones
  function automatic logic [63:0] qmul_sat(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    if (a == 0 || b == 0) return 64'd0;
    if (a == SATV || b == SATV) return SATV;
    prod = a * b;
    if (prod[127:64] != 0) return SATV;
    return prod[63:0] >> FB;
  endfunction

  function automatic logic signed [VW-1:0] next_level(input step_row_t r);
    logic [63:0] rate, lin, lsq, num, den, rate_eff, span, dist_mag, w, w2, p, m;
    logic signed [63:0] sp, tgt, lvl;
    rate = {32'd0, m_base_rate};
    if (r.op == OP_OVERRIDE) rate = {32'd0, r.ovr};
    else if (r.op == OP_SCALED) begin
      rate = qmul_sat({32'd0, m_base_rate}, {40'd0, r.mult});
      if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
    end
    lin = (m_linearity > ONE) ? ONE : {47'd0, m_linearity};
    lsq = (lin * lin) >> FB;
    num = 3 * lsq + 4 * ONE;
    den = 2 * (3 * lsq + ONE);
    rate_eff = (rate / den) * num + ((rate % den) * num) / den;
    sp = 64'(m_high) - 64'(m_low);
    span = (sp < 0) ? -sp : sp;
    if (span == 0) span = ONE;
    tgt = 64'(r.tgt);
    lvl = 64'(m_level);
    dist_mag = (tgt >= lvl) ? tgt - lvl : lvl - tgt;
    w = qmul_sat(dist_mag, ONE - lsq);
    w2 = qmul_sat(lsq, span);
    w = (w == SATV || w2 > SATV - w) ? SATV : w + w2;
    p = qmul_sat(w, rate_eff);
    m = qmul_sat(p, {40'd0, r.dt});
    if (m >= dist_mag) return r.tgt;
    if (tgt > lvl) return VW'(lvl + m);
    return VW'(lvl - m);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_BASE_RATE:  m_base_rate = val;
      CFG_LINEARITY:  m_linearity = val[16:0];
      CFG_LOW_LIMIT:  m_low = val;
      CFG_HIGH_LIMIT: m_high = val;
      CFG_START:      m_level = val;
      default: ;
    endcase
  endtask

  // every item gives a result, so an empty queue means the block is idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // in_valid stays high between beats unless this beat idles first
  task automatic send_step(input step_row_t r);
    if (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 19);
    end
    in_valid <= 1'b1;
    operation <= r.op;
    target_value <= r.tgt;
    time_step <= r.dt;
    rate_override <= r.ovr;
    rate_multiplier <= r.mult;
    do @(posedge clk); while (!in_ready);
    m_level = next_level(r);
    if (r.has_exp && r.exp_level !== m_level)
      report_mismatch("hand value vs predictor", 64'(m_level), 64'(r.exp_level));
    level_q.push_back(r.has_exp ? r.exp_level : m_level);
  endtask

  function automatic step_row_t rand_row();
    step_row_t r;
    int k;
    r.op = OP_W'($urandom_range(3));
    k = $urandom_range(9);
    // four in ten targets near the level so small steps land short of the target
    if (k < 4) r.tgt = m_level + $signed(VW'($urandom_range(32'h4_0000))) - 32'sh2_0000;
    else if (k < 6) r.tgt = $urandom;
    else if (k == 6) r.tgt = ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    else r.tgt = $signed(VW'($urandom_range(32'hA_0000))) - 32'sh5_0000;
    k = $urandom_range(9);
    r.dt = (k < 6) ? TS_W'($urandom_range(2000)) : (k < 9) ? TS_W'($urandom) : '1;
    r.ovr = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4_0000);
    r.mult = ($urandom_range(3) == 0) ? TS_W'($urandom) : TS_W'($urandom_range(32'h2_0000));
    r.has_exp = 1'b0;
    r.exp_level = '0;
    return r;
  endfunction

  task automatic random_config();
    write_reg(CFG_BASE_RATE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4_0000));
    write_reg(CFG_LINEARITY, $urandom_range(32'h1_FFFF));
    write_reg(CFG_LOW_LIMIT, $signed(VW'($urandom_range(32'h10_0000))) - 32'sh8_0000);
    write_reg(CFG_HIGH_LIMIT, ($urandom_range(7) == 0) ? $urandom
                              : $signed(VW'($urandom_range(32'h10_0000))) - 32'sh8_0000);
    write_reg(CFG_START, $signed(VW'($urandom_range(32'h4_0000))) - 32'sh2_0000);
  endtask

  // result side: random stalls, compare against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(smoothed_value), 64'd0);
        end else begin
          if (smoothed_value !== level_q[0])
            report_mismatch("smoothed_value", 64'(smoothed_value), 64'(level_q[0]));
          void'(level_q.pop_front());
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 19);
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  step_row_t directed[$];

  function automatic step_row_t mk(input logic [OP_W-1:0] op, input logic signed [VW-1:0] tgt,
                                   input logic [TS_W-1:0] dt, input logic [VW-1:0] ovr,
                                   input logic [TS_W-1:0] mult, input logic has_exp,
                                   input logic signed [VW-1:0] exp_level);
    step_row_t r;
    r.op = op; r.tgt = tgt; r.dt = dt; r.ovr = ovr; r.mult = mult;
    r.has_exp = has_exp; r.exp_level = exp_level;
    return r;
  endfunction

  initial begin
    errors = 0;
    quiet = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; operation = '0; target_value = '0; time_step = '0;
    rate_override = '0; rate_multiplier = '0;
    m_base_rate = ONE[31:0]; m_linearity = '0; m_low = '0; m_high = ONE[31:0]; m_level = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: rate one, linearity zero, so rate_eff is 2*rate
    // zero time step holds the level at zero
    directed.push_back(mk(OP_BASE, 32'sh0001_0000, 24'd0, 0, 0, 1'b1, 32'sh0));
    // target equal to level: stays put even with zero step
    directed.push_back(mk(OP_BASE, 32'sh0, 24'd0, 0, 0, 1'b1, 32'sh0));
    // full-scale step saturates straight to either extreme
    directed.push_back(mk(OP_BASE, 32'sh7FFF_FFFF, 24'hFF_FFFF, 0, 0, 1'b1, 32'sh7FFF_FFFF));
    directed.push_back(mk(OP_BASE, 32'sh8000_0000, 24'hFF_FFFF, 0, 0, 1'b1, 32'sh8000_0000));
    directed.push_back(mk(OP_OVERRIDE, 32'sh0, 24'd1, 32'hFFFF_FFFF, 0, 1'b0, 0));
    directed.push_back(mk(OP_OVERRIDE, 32'sh10_0000, 24'd300, 32'd0, 0, 1'b0, 0));
    directed.push_back(mk(OP_SCALED, 32'sh10_0000, 24'd300, 0, 24'hFF_FFFF, 1'b0, 0));
    directed.push_back(mk(OP_SCALED, -32'sh10_0000, 24'd500, 0, 24'd0, 1'b0, 0));
    directed.push_back(mk(OP_UNUSED, 32'sh2_0000, 24'd1000, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 0));
    directed.push_back(mk(OP_BASE, -32'sh3_0000, 24'h00_8000, 0, 0, 1'b0, 0));
    foreach (directed[i]) send_step(directed[i]);
    wait_drained();

    // linearity above one clamps; huge base rate with scaling saturates
    write_reg(CFG_BASE_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_LINEARITY, 32'h1_FFFF);
    directed.delete();
    directed.push_back(mk(OP_SCALED, 32'sh4_0000, 24'd20, 0, 24'hFF_FFFF, 1'b0, 0));
    directed.push_back(mk(OP_BASE, -32'sh4_0000, 24'd1, 0, 0, 1'b0, 0));
    // zero span and reversed limits
    foreach (directed[i]) send_step(directed[i]);
    wait_drained();
    write_reg(CFG_LINEARITY, 32'h1_0000);
    write_reg(CFG_BASE_RATE, 32'd1);
    write_reg(CFG_LOW_LIMIT, 32'sh5_0000);
    write_reg(CFG_HIGH_LIMIT, 32'sh5_0000);
    write_reg(CFG_START, 32'sh0);
    directed.delete();
    directed.push_back(mk(OP_BASE, 32'sh9_0000, 24'd7000, 0, 0, 1'b0, 0));
    directed.push_back(mk(OP_OVERRIDE, 32'sh9_0000, 24'd40, 32'h3_0000, 0, 1'b0, 0));
    foreach (directed[i]) send_step(directed[i]);
    wait_drained();
    write_reg(CFG_LOW_LIMIT, 32'sh7FFF_FFFF);
    write_reg(CFG_HIGH_LIMIT, 32'sh8000_0000);
    write_reg(CFG_LINEARITY, 32'h0_8000);
    write_reg(CFG_START, 32'sh8000_0000);
    send_step(mk(OP_BASE, 32'sh7FFF_FFFF, 24'd3, 0, 0, 1'b0, 0));
    send_step(mk(OP_BASE, 32'sh0, 24'd0, 0, 0, 1'b0, 0));
    wait_drained();

    // random phases, each with its own register settings
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      quiet = (ph == 5);
      for (int i = 0; i < N_RANDOM / 12; i++) send_step(rand_row());
      wait_drained();
    end
    quiet = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && level_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (level_q.size() != 0)
        report_mismatch("results never arrived", 64'(level_q.size()), 64'd0);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
